>>> rtl/trimmed_mean_window_filter_unit_assert.svh
// assertion macros of the trimmed mean window filter, used by its controller
`ifndef TRIMMED_MEAN_WINDOW_FILTER_UNIT_ASSERT_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TMWF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TMWF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tmwf_pkg.sv
// shared types and constants of the trimmed mean window filter
package tmwf_pkg;

  localparam int SAMPLE_W = 12;

  typedef struct packed {
    logic acc;
    logic trim;
    logic div_step;
    logic load_out;
  } tmwf_cmd_t;

  typedef struct packed {
    logic last_pos;
  } tmwf_status_t;

endpackage

>>> rtl/trimmed_mean_window_filter_unit.sv
// top level of the trimmed mean window filter
// usage:
//   in_sample arrives on a valid/ready channel, one 12-bit reading per
//   transaction. every WINDOW_SIZE samples form a window; after the last one
//   the block delivers one out_filtered_value transaction holding
//   (sum - min - max) / (WINDOW_SIZE - 2), rounded down.
// timing:
//   a sample that does not close a window is taken while in_ready is high;
//   in_ready stays high for the next sample.
//   the closing sample is followed by a trim state, a reciprocal multiply
//   state and an output load state: the result shows up in the output
//   register as the load state ends, when in_ready also returns.
// reset:
//   synchronous, active low; clears the window and drops any pending result.
// stall:
//   the result waits in the output register while the next window
//   accumulates; only a second finished window waits for out_ready, with
//   in_ready held low until the first result is taken.
module trimmed_mean_window_filter_unit #(
  parameter int WINDOW_SIZE = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tmwf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmwf_pkg::SAMPLE_W-1:0] out_filtered_value
);
  import tmwf_pkg::*;

  // command and status between controller and datapath
  tmwf_cmd_t    cmd;
  tmwf_status_t status;

  tmwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // window accumulators, reciprocal divider and output register
  tmwf_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_sample          (in_sample),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_filtered_value (out_filtered_value)
  );

endmodule

>>> rtl/tmwf_ctrl.sv
// controller state machine of the trimmed mean window filter
`include "trimmed_mean_window_filter_unit_assert.svh"

module tmwf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  tmwf_pkg::tmwf_status_t status_i,
  output tmwf_pkg::tmwf_cmd_t    cmd_o
);
  import tmwf_pkg::*;

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_TRIM = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_ACC);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd_o          = '0;
    unique case (state_r)
      S_ACC: begin
        cmd_o.acc = in_valid;
        if (in_valid && status_i.last_pos) begin
          state_nxt = S_TRIM;
        end
      end
      S_TRIM: begin
        cmd_o.trim = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd_o.load_out = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TMWF_ASSERT_NXT(a_last_blocks_input, cmd_o.acc && status_i.last_pos, !in_ready, "late input")
  `TMWF_ASSERT_NXT(a_trim_starts_div, cmd_o.trim, state_r == S_DIV, "divide did not follow trim")
  `TMWF_ASSERT_NXT(a_div_ends_out, cmd_o.div_step, state_r == S_OUT, "divide end lost")
  `TMWF_ASSERT_NXT(a_out_held, out_valid_r && !out_ready, out_valid_r, "result dropped")

endmodule

>>> rtl/tmwf_datapath.sv
// accumulators, reciprocal divider and output register of the filter
module tmwf_datapath #(
  parameter int WINDOW_SIZE = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tmwf_pkg::SAMPLE_W-1:0] in_sample,
  input  tmwf_pkg::tmwf_cmd_t           cmd_i,
  output tmwf_pkg::tmwf_status_t        status_o,
  output logic [tmwf_pkg::SAMPLE_W-1:0] out_filtered_value
);
  import tmwf_pkg::*;

  localparam int SUM_W   = $clog2(WINDOW_SIZE * 4095 + 1);
  localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
  localparam int DIVISOR = (WINDOW_SIZE > 2) ? WINDOW_SIZE - 2 : 1;
  // rounded-up reciprocal, scaled so the product floor is the exact quotient
  localparam int RCP_SH  = SUM_W + $clog2(DIVISOR);
  localparam int RCP_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RCP_W;
  localparam longint RCP = ((longint'(1) << RCP_SH) + longint'(DIVISOR) - longint'(1))
                           / longint'(DIVISOR);
  localparam logic [RCP_W-1:0] RCP_V = RCP_W'(RCP);

  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] min_r, max_r;
  logic [SUM_W-1:0]    trim_r;
  logic [SAMPLE_W-1:0] q_r;
  logic [SAMPLE_W-1:0] out_r;

  logic [SUM_W-1:0]    trimmed;
  logic [PROD_W-1:0]   prod;

  assign trimmed = sum_r - {{(SUM_W-SAMPLE_W){1'b0}}, min_r}
                         - {{(SUM_W-SAMPLE_W){1'b0}}, max_r};

  assign prod = {{RCP_W{1'b0}}, trim_r} * {{SUM_W{1'b0}}, RCP_V};

  assign status_o.last_pos = (cnt_r == CNT_W'(WINDOW_SIZE - 1));
  assign out_filtered_value = out_r;

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd_i.trim) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end else if (cmd_i.acc) begin
      cnt_r <= cnt_r + CNT_W'(1);
      sum_r <= sum_r + {{(SUM_W-SAMPLE_W){1'b0}}, in_sample};
      if (in_sample < min_r) begin
        min_r <= in_sample;
      end
      if (in_sample > max_r) begin
        max_r <= in_sample;
      end
    end
  end

  // trimmed sum, then quotient from the reciprocal product
  always_ff @(posedge clk) begin
    if (cmd_i.trim) begin
      trim_r <= trimmed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.div_step) begin
      q_r <= prod[RCP_SH +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_r <= q_r;
    end
  end

endmodule
